FILE: rtl/core/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
// Depends on nothing; every module of the allocator imports it.
package ffra_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CREATE,
      S_SCAN,
      S_FIND,
      S_PICK,
      S_ALLOC,
      S_GROW,
      S_GROW2,
      S_FREE_SUM,
      S_FREE_APPLY,
      S_RESP
   } state_type;

   // Commands broadcast to the cell row
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_WRITE,
      CMD_SHR,
      CMD_SHL,
      CMD_SHL_WR,
      CMD_FLAGS
   } cmd_type;

   typedef logic [1:0] status_type;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_NOFIT = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_INITIAL_SIZE = 1'b0;
   localparam logic CSR_GROW_ENABLED = 1'b1;

endpackage

FILE: rtl/core/ffra_cell.sv
// One entry of the free-range table: start, length and compare flags.
// Depends on ffra_pkg for the command codes.
module ffra_cell #(
   parameter int CELL_IDX  = 0,
   parameter int IW        = 6,
   parameter int SIZE_BITS = 48
) (
   input  logic                 clock,
   input  ffra_pkg::cmd_type    cmd,
   input  logic [IW-1:0]        sel_pos,
   input  logic [SIZE_BITS-1:0] key,
   input  logic [SIZE_BITS-1:0] wr_start,
   input  logic [SIZE_BITS-1:0] wr_len,
   input  logic [SIZE_BITS-1:0] left_start,
   input  logic [SIZE_BITS-1:0] left_len,
   input  logic [SIZE_BITS-1:0] right_start,
   input  logic [SIZE_BITS-1:0] right_len,
   output logic [SIZE_BITS-1:0] cell_start,
   output logic [SIZE_BITS-1:0] cell_len,
   output logic                 fit,
   output logic                 ge
);
   import ffra_pkg::*;

   localparam logic [IW:0] ME = (IW+1)'(CELL_IDX);

   logic [SIZE_BITS-1:0] start_ff, start_in;
   logic [SIZE_BITS-1:0] len_ff, len_in;
   logic                 fit_ff, fit_in;
   logic                 ge_ff, ge_in;
   logic [IW:0]          pos_x;

   assign pos_x = {1'b0, sel_pos};

   // Select the entry's next contents from the command
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      fit_in   = fit_ff;
      ge_in    = ge_ff;
      case (cmd)
         CMD_WRITE: begin
            if (ME == pos_x) begin
               start_in = wr_start;
               len_in   = wr_len;
            end
         end
         CMD_SHR: begin
            if (ME == pos_x) begin
               start_in = wr_start;
               len_in   = wr_len;
            end else if (ME > pos_x) begin
               start_in = left_start;
               len_in   = left_len;
            end
         end
         CMD_SHL: begin
            if (ME >= pos_x) begin
               start_in = right_start;
               len_in   = right_len;
            end
         end
         CMD_SHL_WR: begin
            if (ME >= pos_x) begin
               start_in = right_start;
               len_in   = right_len;
            end else if (ME + 1'b1 == pos_x) begin
               start_in = wr_start;
               len_in   = wr_len;
            end
         end
         CMD_FLAGS: begin
            fit_in = (len_ff >= key);
            ge_in  = (start_ff >= key);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      fit_ff   <= fit_in;
      ge_ff    <= ge_in;
   end

   assign cell_start = start_ff;
   assign cell_len   = len_ff;
   assign fit        = fit_ff;
   assign ge         = ge_ff;

endmodule

FILE: rtl/core/first_fit_range_allocator.sv
// Top level of the first-fit range allocator: sequencer, counters and cell row.
// Depends on ffra_pkg and ffra_cell.
// An allocate that fits passes scan, find, pick and alloc before the response; a free
// passes scan, find, pick, free-sum and free-apply. Creation adds the create state and
// growth the grow states. A full table answers a free from idle and a creation from
// the create state. One request in flight; busy stays high through the strobe, so the
// next start is taken after it. The cell row flags all entries in parallel; the first
// match is encoded and read out. Synchronous reset empties the table and control state.
module first_fit_range_allocator #(
   parameter int MAX_RANGES = 64,
   parameter int SIZE_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic [SIZE_BITS-1:0]   req_length,
   input  logic [SIZE_BITS-1:0]   req_start_req,
   output logic                   rsp_valid,
   output logic [SIZE_BITS-1:0]   rsp_alloc_offset,
   output ffra_pkg::status_type   rsp_status,
   output logic [SIZE_BITS-1:0]   rsp_used_bytes,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [SIZE_BITS-1:0]   csr_wdata
);
   import ffra_pkg::*;

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
   localparam logic [SIZE_BITS-1:0] SZ_MASK = {SIZE_BITS{1'b1}};

   state_type state_ff, state_in;

   logic                 func_ff, func_in;
   logic [SIZE_BITS-1:0] len_ff, len_in;
   logic [SIZE_BITS-1:0] sreq_ff, sreq_in;
   logic [SIZE_BITS-1:0] init_size_ff, init_size_in;
   logic                 grow_ff, grow_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SIZE_BITS-1:0] cap_ff, cap_in;
   logic [SIZE_BITS-1:0] freetot_ff, freetot_in;
   logic                 created_ff, created_in;
   logic [IW-1:0]        pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [SIZE_BITS-1:0] hit_start_ff, hit_start_in;
   logic [SIZE_BITS-1:0] hit_len_ff, hit_len_in;
   logic [SIZE_BITS-1:0] prv_start_ff, prv_start_in;
   logic [SIZE_BITS-1:0] prv_len_ff, prv_len_in;
   logic                 nxt_ok_ff, nxt_ok_in;
   logic                 prv_ok_ff, prv_ok_in;
   logic [SIZE_BITS-1:0] sum_ff, sum_in;
   logic [SIZE_BITS-1:0] off_ff, off_in;
   status_type           status_ff, status_in;
   logic [SIZE_BITS-1:0] ga_ff, ga_in;
   logic [SIZE_BITS-1:0] gb_ff, gb_in;

   // Cell row control
   cmd_type              cmd;
   logic [IW-1:0]        sel_pos;
   logic [SIZE_BITS-1:0] key;
   logic [SIZE_BITS-1:0] wr_start;
   logic [SIZE_BITS-1:0] wr_len;

   logic [SIZE_BITS-1:0] cell_start [MAX_RANGES];
   logic [SIZE_BITS-1:0] cell_len   [MAX_RANGES];
   logic [MAX_RANGES-1:0] fit_raw, ge_raw, valid_mask;

   logic                 accept;
   logic                 full;
   logic [SIZE_BITS-1:0] create_sz;
   logic [IW-1:0]        first_idx;
   logic                 first_any;
   logic [SIZE_BITS-1:0] pick_start, pick_len, pick_pstart, pick_plen;
   logic [SIZE_BITS:0]   sat_sum;
   logic [SIZE_BITS+1:0] tri_sum;
   logic [SIZE_BITS-1:0] grow_nc, grow_tail;
   logic [IW-1:0]        count_idx;

   assign accept    = start && !busy;
   assign full      = (count_ff >= CNT_MAX);
   assign create_sz = (len_ff > init_size_ff) ? len_ff : init_size_ff;
   assign count_idx = count_ff[IW-1:0];
   assign key       = (func_ff == FUNC_FREE) ? sreq_ff : len_ff;
   assign sat_sum   = {1'b0, cap_ff} + {1'b0, len_ff};
   assign tri_sum   = {2'b00, cap_ff} + {1'b0, cap_ff, 1'b0};
   assign grow_nc   = (ga_ff > gb_ff) ? ga_ff : gb_ff;
   assign grow_tail = grow_nc - cap_ff;

   // Build the cell row; each cell sees its neighbors
   for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
      logic [SIZE_BITS-1:0] l_start, l_len, r_start, r_len;
      if (k == 0) begin : g_left_edge
         assign l_start = '0;
         assign l_len   = '0;
      end else begin : g_left
         assign l_start = cell_start[k-1];
         assign l_len   = cell_len[k-1];
      end
      if (k == MAX_RANGES - 1) begin : g_right_edge
         assign r_start = '0;
         assign r_len   = '0;
      end else begin : g_right
         assign r_start = cell_start[k+1];
         assign r_len   = cell_len[k+1];
      end
      ffra_cell #(
         .CELL_IDX  (k),
         .IW        (IW),
         .SIZE_BITS (SIZE_BITS)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .sel_pos     (sel_pos),
         .key         (key),
         .wr_start    (wr_start),
         .wr_len      (wr_len),
         .left_start  (l_start),
         .left_len    (l_len),
         .right_start (r_start),
         .right_len   (r_len),
         .cell_start  (cell_start[k]),
         .cell_len    (cell_len[k]),
         .fit         (fit_raw[k]),
         .ge          (ge_raw[k])
      );
      assign valid_mask[k] = (CW'(k) < count_ff);
   end

   // Encode the first flagged live entry
   always_comb begin
      logic [MAX_RANGES-1:0] flags;
      flags     = ((func_ff == FUNC_FREE) ? ge_raw : fit_raw) & valid_mask;
      first_idx = '0;
      first_any = 1'b0;
      for (int k = MAX_RANGES - 1; k >= 0; k--) begin
         if (flags[k]) begin
            first_idx = IW'(k);
            first_any = 1'b1;
         end
      end
   end

   // Read out the chosen entry and its predecessor
   always_comb begin
      pick_start  = '0;
      pick_len    = '0;
      pick_pstart = '0;
      pick_plen   = '0;
      for (int k = 0; k < MAX_RANGES; k++) begin
         if (IW'(k) == pos_ff) begin
            pick_start = pick_start | cell_start[k];
            pick_len   = pick_len | cell_len[k];
         end
         if ((IW+1)'(k) + 1'b1 == {1'b0, pos_ff}) begin
            pick_pstart = pick_pstart | cell_start[k];
            pick_plen   = pick_plen | cell_len[k];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_FREE) begin
                  state_in = full ? S_RESP : S_SCAN;
               end else begin
                  state_in = created_ff ? S_SCAN : S_CREATE;
               end
            end
         end
         S_CREATE:   state_in = full ? S_RESP : S_SCAN;
         S_SCAN:     state_in = S_FIND;
         S_FIND:     state_in = S_PICK;
         S_PICK: begin
            if (func_ff == FUNC_FREE) begin
               state_in = S_FREE_SUM;
            end else begin
               state_in = found_ff ? S_ALLOC : S_GROW;
            end
         end
         S_ALLOC:    state_in = S_RESP;
         S_GROW:     state_in = grow_ff ? S_GROW2 : S_RESP;
         S_GROW2: begin
            if (grow_nc <= cap_ff || full || grow_tail < len_ff) begin
               state_in = S_RESP;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_FREE_SUM:   state_in = S_FREE_APPLY;
         S_FREE_APPLY: state_in = S_RESP;
         S_RESP:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Datapath updates and cell commands
   always_comb begin
      func_in      = func_ff;
      len_in       = len_ff;
      sreq_in      = sreq_ff;
      init_size_in = init_size_ff;
      grow_in      = grow_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      freetot_in   = freetot_ff;
      created_in   = created_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      hit_start_in = hit_start_ff;
      hit_len_in   = hit_len_ff;
      prv_start_in = prv_start_ff;
      prv_len_in   = prv_len_ff;
      nxt_ok_in    = nxt_ok_ff;
      prv_ok_in    = prv_ok_ff;
      sum_in       = sum_ff;
      off_in       = off_ff;
      status_in    = status_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      cmd          = CMD_HOLD;
      sel_pos      = pos_ff;
      wr_start     = '0;
      wr_len       = '0;

      // Apply register writes
      if (csr_we) begin
         if (csr_index == CSR_INITIAL_SIZE) begin
            init_size_in = csr_wdata;
         end else begin
            grow_in = csr_wdata[0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_func;
               len_in    = req_length;
               sreq_in   = req_start_req;
               off_in    = '0;
               status_in = (req_func == FUNC_FREE && full) ? STAT_FULL : STAT_OK;
            end
         end
         S_CREATE: begin
            // Append the whole region as one free range
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               cmd        = CMD_WRITE;
               sel_pos    = count_idx;
               wr_start   = '0;
               wr_len     = create_sz;
               count_in   = count_ff + 1'b1;
               cap_in     = create_sz;
               freetot_in = freetot_ff + create_sz;
               created_in = 1'b1;
            end
         end
         S_SCAN: begin
            cmd = CMD_FLAGS;
         end
         S_FIND: begin
            found_in = first_any;
            pos_in   = first_any ? first_idx : count_idx;
         end
         S_PICK: begin
            hit_start_in = pick_start;
            hit_len_in   = pick_len;
            prv_start_in = pick_pstart;
            prv_len_in   = pick_plen;
         end
         S_ALLOC: begin
            // Carve from the front, or drop the entry when used up
            off_in     = hit_start_ff;
            status_in  = STAT_OK;
            freetot_in = freetot_ff - len_ff;
            if (hit_len_ff > len_ff) begin
               cmd      = CMD_WRITE;
               wr_start = hit_start_ff + len_ff;
               wr_len   = hit_len_ff - len_ff;
            end else begin
               cmd      = CMD_SHL;
               count_in = count_ff - 1'b1;
            end
         end
         S_GROW: begin
            status_in = STAT_NOFIT;
            ga_in     = sat_sum[SIZE_BITS] ? SZ_MASK : sat_sum[SIZE_BITS-1:0];
            gb_in     = (tri_sum[SIZE_BITS+1:SIZE_BITS] != 2'b00) ? SZ_MASK
                                                                 : tri_sum[SIZE_BITS-1:0];
         end
         S_GROW2: begin
            // Append the grown tail and aim the carve at it
            if (grow_nc <= cap_ff) begin
               status_in = STAT_NOFIT;
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               cmd          = CMD_WRITE;
               sel_pos      = count_idx;
               wr_start     = cap_ff;
               wr_len       = grow_tail;
               count_in     = count_ff + 1'b1;
               freetot_in   = freetot_ff + grow_tail;
               cap_in       = grow_nc;
               pos_in       = count_idx;
               hit_start_in = cap_ff;
               hit_len_in   = grow_tail;
               status_in    = STAT_NOFIT;
            end
         end
         S_FREE_SUM: begin
            nxt_ok_in = ({1'b0, pos_ff} != (IW+1)'(count_ff)) &&
                        (sreq_ff + len_ff == hit_start_ff);
            prv_ok_in = (pos_ff != '0) && (prv_start_ff + prv_len_ff == sreq_ff);
            sum_in    = len_ff + hit_len_ff;
         end
         S_FREE_APPLY: begin
            // Insert, or merge with the neighbors on exact adjacency
            status_in  = STAT_OK;
            freetot_in = freetot_ff + len_ff;
            if (prv_ok_ff && nxt_ok_ff) begin
               cmd      = CMD_SHL_WR;
               wr_start = prv_start_ff;
               wr_len   = prv_len_ff + sum_ff;
               count_in = count_ff - 1'b1;
            end else if (prv_ok_ff) begin
               cmd      = CMD_WRITE;
               sel_pos  = pos_ff - 1'b1;
               wr_start = prv_start_ff;
               wr_len   = prv_len_ff + len_ff;
            end else if (nxt_ok_ff) begin
               cmd      = CMD_WRITE;
               wr_start = sreq_ff;
               wr_len   = sum_ff;
            end else begin
               cmd      = CMD_SHR;
               wr_start = sreq_ff;
               wr_len   = len_ff;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_size_ff <= '0;
         grow_ff      <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= '0;
         freetot_ff   <= '0;
         created_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_size_ff <= init_size_in;
         grow_ff      <= grow_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         freetot_ff   <= freetot_in;
         created_ff   <= created_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      len_ff       <= len_in;
      sreq_ff      <= sreq_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      hit_start_ff <= hit_start_in;
      hit_len_ff   <= hit_len_in;
      prv_start_ff <= prv_start_in;
      prv_len_ff   <= prv_len_in;
      nxt_ok_ff    <= nxt_ok_in;
      prv_ok_ff    <= prv_ok_in;
      sum_ff       <= sum_in;
      off_ff       <= off_in;
      status_ff    <= status_in;
      ga_ff        <= ga_in;
      gb_ff        <= gb_in;
   end

   // Present the transfer for one cycle
   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_alloc_offset = off_ff;
   assign rsp_status       = status_ff;
   assign rsp_used_bytes   = cap_ff - freetot_ff;

endmodule

FILE: dv/tb_first_fit_range_allocator.sv
// Testbench for first_fit_range_allocator: a model-based scoreboard class and the top module.
// Depends on ffra_pkg and the RTL of first_fit_range_allocator; reads no files.
// Covers directed corner cases, then three randomized phases with different sender gaps.

typedef struct {
   bit [47:0]            offset;
   ffra_pkg::status_type status;
   bit [47:0]            used;
} alloc_result_type;

class alloc_scoreboard;
   localparam bit [47:0] MASK = 48'hFFFF_FFFF_FFFF;
   localparam int        SLOTS = 64;

   bit [47:0]        seg_start[SLOTS];
   bit [47:0]        seg_len[SLOTS];
   int               seg_count;
   bit [47:0]        cap;
   bit               made;
   bit [47:0]        init_sz;
   bit               grow_on;
   alloc_result_type pending[$];
   int               errors;
   int               checked;

   // Log one mismatch and count it
   task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   function void write_reg(logic idx, bit [47:0] val);
      if (idx == ffra_pkg::CSR_INITIAL_SIZE) init_sz = val;
      else grow_on = val[0];
   endfunction

   function void drop_seg(int i);
      for (int k = i; k + 1 < seg_count; k++) begin
         seg_start[k] = seg_start[k + 1];
         seg_len[k]   = seg_len[k + 1];
      end
      seg_count--;
   endfunction

   function bit push_seg(bit [47:0] s, bit [47:0] l);
      if (seg_count >= SLOTS) return 0;
      seg_start[seg_count] = s;
      seg_len[seg_count]   = l;
      seg_count++;
      return 1;
   endfunction

   function int first_fit(bit [47:0] len);
      for (int i = 0; i < seg_count; i++)
         if (seg_len[i] >= len) return i;
      return SLOTS;
   endfunction

   function bit [47:0] used_now();
      bit [47:0] f;
      f = '0;
      for (int i = 0; i < seg_count; i++) f = f + seg_len[i];
      return cap - f;
   endfunction

   function ffra_pkg::status_type carve(bit [47:0] len, output bit [47:0] off);
      bit [48:0] sum;
      bit [49:0] tri_cap;
      bit [47:0] grown_a, grown_b, nc;
      int        i;
      off = '0;
      // Create the region on first allocate
      if (!made) begin
         if (!push_seg(48'd0, (len > init_sz) ? len : init_sz)) return ffra_pkg::STAT_FULL;
         cap  = (len > init_sz) ? len : init_sz;
         made = 1;
      end
      i = first_fit(len);
      if (i >= SLOTS) begin
         if (!grow_on) return ffra_pkg::STAT_NOFIT;
         sum     = {1'b0, cap} + {1'b0, len};
         grown_a = sum[48] ? MASK : sum[47:0];
         tri_cap = {2'b00, cap} * 50'd3;
         grown_b = (cap > MASK / 3) ? MASK : tri_cap[47:0];
         nc      = (grown_a > grown_b) ? grown_a : grown_b;
         if (nc <= cap) return ffra_pkg::STAT_NOFIT;
         if (!push_seg(cap, nc - cap)) return ffra_pkg::STAT_FULL;
         cap = nc;
         i   = first_fit(len);
         if (i >= SLOTS) return ffra_pkg::STAT_NOFIT;
      end
      off = seg_start[i];
      if (seg_len[i] > len) begin
         seg_start[i] = seg_start[i] + len;
         seg_len[i]   = seg_len[i] - len;
      end else begin
         drop_seg(i);
      end
      return ffra_pkg::STAT_OK;
   endfunction

   function ffra_pkg::status_type release_range(bit [47:0] s, bit [47:0] l);
      int pos;
      if (seg_count >= SLOTS) return ffra_pkg::STAT_FULL;
      pos = 0;
      while (pos < seg_count && seg_start[pos] < s) pos++;
      for (int k = seg_count; k > pos; k--) begin
         seg_start[k] = seg_start[k - 1];
         seg_len[k]   = seg_len[k - 1];
      end
      seg_start[pos] = s;
      seg_len[pos]   = l;
      seg_count++;
      // Merge with the following range, then with the preceding one
      if (pos + 1 < seg_count && seg_start[pos] + seg_len[pos] == seg_start[pos + 1]) begin
         seg_len[pos] = seg_len[pos] + seg_len[pos + 1];
         drop_seg(pos + 1);
      end
      if (pos > 0 && seg_start[pos - 1] + seg_len[pos - 1] == seg_start[pos]) begin
         seg_len[pos - 1] = seg_len[pos - 1] + seg_len[pos];
         drop_seg(pos);
      end
      return ffra_pkg::STAT_OK;
   endfunction

   // Note an accepted request and queue the result it must produce
   function alloc_result_type note_request(logic func, bit [47:0] len, bit [47:0] s);
      alloc_result_type r;
      r.offset = '0;
      if (func == ffra_pkg::FUNC_ALLOC) r.status = carve(len, r.offset);
      else r.status = release_range(s, len);
      r.used = used_now();
      pending.insert(pending.size(), r);
      return r;
   endfunction

   // Compare a result transfer with the oldest expectation
   task check_result(bit [47:0] off, ffra_pkg::status_type st, bit [47:0] used);
      alloc_result_type e;
      if (pending.size() == 0) begin
         report("result with nothing expected");
         return;
      end
      e = pending.pop_front();
      checked++;
      if (off !== e.offset) report($sformatf("offset %h, want %h", off, e.offset));
      if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
      if (used !== e.used) report($sformatf("used %h, want %h", used, e.used));
   endtask
endclass

module tb_first_fit_range_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import ffra_pkg::*;

   typedef struct {
      bit [47:0] offset;
      bit [47:0] len;
   } block_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_func;
   logic [47:0]          req_length;
   logic [47:0]          req_start_req;
   logic                 rsp_valid;
   logic [47:0]          rsp_alloc_offset;
   status_type           rsp_status;
   logic [47:0]          rsp_used_bytes;
   logic                 csr_we;
   logic                 csr_index;
   logic [47:0]          csr_wdata;

   alloc_scoreboard sb;
   block_type       live[$];
   int              gap_pct;
   int              n_alloc;
   int              n_free;

   first_fit_range_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_length(req_length), .req_start_req(req_start_req),
      .rsp_valid(rsp_valid), .rsp_alloc_offset(rsp_alloc_offset),
      .rsp_status(rsp_status), .rsp_used_bytes(rsp_used_bytes),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_alloc_offset, rsp_status, rsp_used_bytes);
   end

   // Hard stop for a hung run
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   function bit [47:0] rand48();
      bit [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   // Issue one request and hold it until the transfer happens
   task issue(logic func, bit [47:0] len, bit [47:0] s);
      alloc_result_type r;
      block_type        b;
      req_func      <= func;
      req_length    <= len;
      req_start_req <= s;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      r = sb.note_request(func, len, s);
      if (func == FUNC_ALLOC) n_alloc++;
      else n_free++;
      if (func == FUNC_ALLOC && r.status == STAT_OK && len != 0) begin
         b.offset = r.offset;
         b.len    = len;
         live.insert(live.size(), b);
      end
      // Idle the sender now and then
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drain, let the block settle, then write one register
   task write_csr(logic idx, bit [47:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task random_items(int count, bit wide);
      bit [47:0] len;
      int        pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 50) begin
            pick = $urandom_range(99);
            if (pick < 70) len = 48'($urandom_range(1, 256));
            else if (pick < 90) len = 48'($urandom_range(0, 4096));
            else if (pick < 95 || !wide) len = '0;
            else len = rand48();
            issue(FUNC_ALLOC, len, rand48());
         end else if (live.size() != 0 && $urandom_range(99) < 80) begin
            pick = $urandom_range(live.size() - 1);
            issue(FUNC_FREE, live[pick].len, live[pick].offset);
            live.delete(pick);
         end else if (wide) begin
            issue(FUNC_FREE, rand48(), rand48());
         end else begin
            issue(FUNC_FREE, 48'($urandom_range(0, 64)), 48'($urandom_range(0, 1 << 20)));
         end
      end
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_func      = FUNC_ALLOC;
      req_length    = '0;
      req_start_req = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_INITIAL_SIZE;
      csr_wdata     = '0;
      gap_pct       = 24;
      n_alloc       = 0;
      n_free        = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: free before creation, zero-length create, no fit, exact fit
      write_csr(CSR_INITIAL_SIZE, 48'd256);
      write_csr(CSR_GROW_ENABLED, 48'd0);
      issue(FUNC_FREE, 48'd16, 48'h10_0000);
      issue(FUNC_ALLOC, 48'd0, 48'h0);
      issue(FUNC_ALLOC, 48'd300, 48'hFFFF_FFFF_FFFF);
      issue(FUNC_ALLOC, 48'd16, 48'h0);
      issue(FUNC_FREE, 48'd0, 48'h40);
      issue(FUNC_FREE, 48'd16, 48'h30);
      // Fill the table, then hit it full on free and on growth
      for (int i = 0; sb.seg_count < 64; i++)
         issue(FUNC_FREE, 48'd8, 48'h20_0000 + 48'(i) * 48'd32);
      issue(FUNC_FREE, 48'd8, 48'h100);
      write_csr(CSR_GROW_ENABLED, 48'd1);
      issue(FUNC_ALLOC, 48'h10_0000, 48'h0);

      // Phase A: sender gaps at 24%, growth on
      random_items(480, 0);

      // Phase B: sender gaps at 79%, growth off
      write_csr(CSR_INITIAL_SIZE, rand48());
      write_csr(CSR_GROW_ENABLED, 48'd0);
      gap_pct = 79;
      random_items(480, 0);

      // Phase C: no gaps, growth on, wide values and saturation
      write_csr(CSR_INITIAL_SIZE, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_GROW_ENABLED, 48'd1);
      gap_pct = 0;
      random_items(420, 1);
      issue(FUNC_ALLOC, 48'hFFFF_FFFF_FFFF, 48'h0);
      issue(FUNC_ALLOC, 48'hFFFF_FFFF_FFFF, 48'h0);
      issue(FUNC_FREE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      random_items(30, 1);

      // Wait for the last results, then settle
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d allocates and %0d frees; %0d results checked, %0d mismatches.",
               n_alloc, n_free, sb.checked, sb.errors);
      if (sb.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
